FILE: src/spectral_peak_picker_core_defines.svh
// assertion macros for the spectral peak picker
`ifndef SPECTRAL_PEAK_PICKER_CORE_DEFINES_SVH
`define SPECTRAL_PEAK_PICKER_CORE_DEFINES_SVH
// implication checked on every rising clock edge out of reset
`define SPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: src/spp_pkg.sv
// shared types, constants and helpers of the spectral peak picker
`default_nettype none
package spp_pkg;
    localparam int MAX_BIN_DEF     = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int BIN_W = 13;
    localparam int SQ_W  = 48;
    localparam int EN_W  = 60;
    localparam int MAG_W = 24;
    localparam int OFS_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BIN_W-1:0] BIN_SAT = '1;
    localparam logic [EN_W-1:0]  ENERGY_MAX = '1;

    localparam logic [1:0] REG_MIN_BIN   = 2'd0;
    localparam logic [1:0] REG_MAX_BIN   = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    typedef struct packed {
        logic signed [23:0] real_part;
        logic signed [23:0] imag_part;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]        peak_bin;
        logic signed [OFS_W-1:0] peak_offset;
        logic [MAG_W-1:0]        peak_magnitude;
        logic [EN_W-1:0]         band_energy;
        logic                    detected;
    } t_out_item;

    // frame summary handed from front to back
    typedef struct packed {
        logic [SQ_W-1:0]  best_sq;
        logic [SQ_W-1:0]  left_sq;
        logic [SQ_W-1:0]  right_sq;
        logic [BIN_W-1:0] best_idx;
        logic             interp;
        logic [EN_W-1:0]  energy;
    } t_frame;

    typedef enum logic [2:0] {
        S_IDLE, S_SQRT_C, S_SQRT_L, S_SQRT_R, S_DIV, S_DONE
    } t_back_state;
endpackage
`default_nettype wire

FILE: src/spectral_peak_picker_core.sv
// top level of the spectral peak picker
// result path: the front end (absolute values, squares, peak tracking), the summary queue,
// then the back end; interpolation adds two roots and the divider, skipped when flat
// throughput: one bin per cycle while the queue has room; the back end takes one frame at a
// time, and a two-entry summary queue absorbs short frames before the input stalls
// reset: synchronous active low, registers return to 1 / 256 / 8, frame state clears
`default_nettype none
`include "spectral_peak_picker_core_defines.svh"
module spectral_peak_picker_core
    import spp_pkg::*;
#(
    parameter int MAX_BIN     = MAX_BIN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire t_in_item    i_item,
    output logic             o_valid,
    input  wire logic        i_stall,
    output t_out_item        o_item,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [BIN_W-1:0] r_min, r_max;
    logic [MAG_W-1:0] r_thr;
    logic   push, full, empty, pop, busy;
    t_frame fr_in, fr_out;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= BIN_W'(1); r_max <= BIN_W'(256); r_thr <= MAG_W'(8);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MIN_BIN:   r_min <= pwdata[BIN_W-1:0];
                REG_MAX_BIN:   r_max <= pwdata[BIN_W-1:0];
                REG_THRESHOLD: r_thr <= pwdata[MAG_W-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_MIN_BIN:   prdata = 32'(r_min);
            REG_MAX_BIN:   prdata = 32'(r_max);
            REG_THRESHOLD: prdata = 32'(r_thr);
            default:       prdata = '0;
        endcase
    end

    spp_front #(.MAX_BIN(MAX_BIN), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .i_min_bin(r_min), .i_max_bin(r_max),
        .o_push(push), .o_frame(fr_in), .i_full(full), .o_busy(busy)
    );
    spp_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data(fr_in), .o_full(full),
        .o_empty(empty), .i_pop(pop), .o_data(fr_out)
    );
    spp_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_frame(fr_out), .o_pop(pop),
        .i_threshold(r_thr), .o_valid, .i_stall, .o_item
    );

    `SPP_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, pop, !empty, "pop from empty queue")
    `SPP_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, push, !full, "push into full queue")
    `SPP_ASSERT_NEXT(a_pop_valid, i_clk, i_rst_n, pop, o_valid, "result lost after pop")
    `SPP_ASSERT_IMP(a_push_busy, i_clk, i_rst_n, push, busy, "push without a bin in the pipe")
    `SPP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_item), "stalled result changed")
endmodule
`default_nettype wire

FILE: src/spp_front.sv
// front end: per-bin squaring, band energy and peak tracking, one bin a cycle while the queue has room
`default_nettype none
module spp_front
    import spp_pkg::*;
#(
    parameter int MAX_BIN     = MAX_BIN_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire t_in_item         i_item,
    input  wire logic [BIN_W-1:0] i_min_bin,
    input  wire logic [BIN_W-1:0] i_max_bin,
    output logic                  o_push,
    output t_frame                o_frame,
    input  wire logic             i_full,
    output logic                  o_busy
);
    localparam logic [BIN_W-1:0] MAXB = BIN_W'(MAX_BIN);
    localparam int PW = SAMPLE_BITS;

    // stage 1: absolute values
    logic            r_v1, r_end1;
    logic [PW-1:0]   r_re, r_im;
    // stage 2: squares
    logic            r_v2, r_end2;
    logic [SQ_W-1:0] r_sq;

    logic [BIN_W-1:0] r_cnt, r_best_idx;
    logic [SQ_W-1:0]  r_best, r_prev, r_left, r_right;
    logic             r_pend;
    logic [EN_W-1:0]  r_energy;

    logic [BIN_W-1:0] lo, hi;
    logic             acc, in_band, better;
    logic [EN_W:0]    esum;
    logic [SQ_W-1:0]  right_now;

    function automatic logic [PW-1:0] part_abs(input logic [23:0] raw);
        logic [PW-1:0] v;
        v = raw[PW-1:0];
        if (v[PW-1]) v = ~v + 1'b1;
        return v;
    endfunction

    // result stage may push only when the queue has room; stall whole pipe then
    assign o_stall = i_full;
    assign acc     = i_valid && !o_stall;
    assign o_busy  = r_v1 || r_v2;

    assign lo = (i_min_bin == '0) ? BIN_W'(1) : i_min_bin;
    assign hi = (i_max_bin > MAXB) ? MAXB : i_max_bin;
    assign in_band = (r_cnt >= lo) && (r_cnt <= hi);
    assign better  = in_band && (r_sq > r_best);
    assign esum    = {1'b0, r_energy} + EN_W'(r_sq) + (EN_W+1)'(0);
    assign right_now = r_pend ? r_sq : r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (!o_stall) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
        end
        if (!o_stall) begin
            r_re   <= part_abs(i_item.real_part);
            r_im   <= part_abs(i_item.imag_part);
            r_end1 <= i_item.frame_end;
            r_sq   <= SQ_W'({24'd0, r_re} * {24'd0, r_re}) + SQ_W'({24'd0, r_im} * {24'd0, r_im});
            r_end2 <= r_end1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_best <= '0; r_best_idx <= '0; r_prev <= '0;
            r_left <= '0; r_right <= '0; r_pend <= 1'b0; r_energy <= '0;
        end else if (r_v2 && !o_stall) begin
            if (r_end2) begin
                r_cnt <= '0; r_best <= '0; r_best_idx <= '0; r_prev <= '0;
                r_left <= '0; r_right <= '0; r_pend <= 1'b0; r_energy <= '0;
            end else begin
                r_right <= better ? '0 : right_now;
                r_pend  <= better ? 1'b1 : 1'b0;
                if (in_band) r_energy <= esum[EN_W] ? ENERGY_MAX : esum[EN_W-1:0];
                if (better) begin
                    r_best     <= r_sq;
                    r_best_idx <= r_cnt;
                    r_left     <= r_prev;
                end
                r_prev <= r_sq;
                if (r_cnt != BIN_SAT) r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // frame summary from the last bin
    always_comb begin
        o_push = r_v2 && r_end2 && !o_stall;
        o_frame.best_sq  = better ? r_sq : r_best;
        o_frame.best_idx = better ? r_cnt : r_best_idx;
        o_frame.left_sq  = better ? r_prev : r_left;
        o_frame.right_sq = better ? '0 : right_now;
        o_frame.energy   = !in_band ? r_energy : (esum[EN_W] ? ENERGY_MAX : esum[EN_W-1:0]);
        o_frame.interp   = (o_frame.best_idx > lo) && (o_frame.best_idx < hi);
    end
endmodule
`default_nettype wire

FILE: src/spp_queue.sv
// short frame-summary queue between front and back
`default_nettype none
module spp_queue
    import spp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_frame i_data,
    output logic        o_full,
    output logic        o_empty,
    input  wire logic   i_pop,
    output t_frame      o_data
);
    t_frame r_mem [QUEUE_DEPTH];
    logic [$clog2(QUEUE_DEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QUEUE_DEPTH):0]   r_cnt;

    assign o_full  = (r_cnt == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (i_push ? 1'b1 : 1'b0) - (i_pop ? 1'b1 : 1'b0);
        end
    end
endmodule
`default_nettype wire

FILE: src/spp_back.sv
// back end: shared iterative square root and divider, then the result register
`default_nettype none
module spp_back
    import spp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire t_frame           i_frame,
    output logic                  o_pop,
    input  wire logic [MAG_W-1:0] i_threshold,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output t_out_item             o_item
);
    t_back_state r_state, n_state;
    logic [SQ_W-1:0]  r_x;     // sqrt radicand
    logic [MAG_W-1:0] r_root;
    logic [4:0]       r_step;
    logic [MAG_W-1:0] r_c, r_l, r_r;
    logic [40:0]      r_rem, r_quo;
    logic [26:0]      r_den;
    logic             r_neg;
    logic [5:0]       r_dstep;
    logic             r_valid;
    t_out_item        r_item;

    logic             st_load, sqrt_done, div_done, den_ok;
    logic [MAG_W+1:0] c2, lr;
    logic [MAG_W-1:0] diff;
    logic [MAG_W-1:0] root_nx;
    logic [41:0]      rem_sh;
    logic signed [OFS_W-1:0] ofs;
    logic [SQ_W-1:0]  sq_try;
    logic [41:0]      qr;

    // restoring root: one result bit per cycle
    assign root_nx   = r_root | (MAG_W'(1) << r_step);
    assign sqrt_done = (r_step == 5'd0);
    assign div_done  = (r_dstep == 6'd0);

    assign sq_try = SQ_W'({24'd0, root_nx} * {24'd0, root_nx});

    assign c2 = {1'b0, r_c, 1'b0};
    assign lr = (MAG_W+2)'(r_l) + (MAG_W+2)'(r_r);
    assign den_ok = (c2 >= lr) && (c2 != lr);
    assign diff = (r_r < r_l) ? r_l - r_r : r_r - r_l;
    assign rem_sh = {r_rem, r_quo[40]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (!i_empty) n_state = S_SQRT_C;
            S_SQRT_C: if (sqrt_done) n_state = i_frame.interp ? S_SQRT_L : S_DONE;
            S_SQRT_L: if (sqrt_done) n_state = S_SQRT_R;
            S_SQRT_R: if (sqrt_done) n_state = S_DIV;
            S_DIV:    if (div_done || !den_ok) n_state = S_DONE;
            S_DONE:   if (!r_valid || !i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        st_load = (r_state == S_IDLE) && !i_empty;
        o_pop   = (r_state == S_DONE) && (!r_valid || !i_stall);
    end

    // rounded quotient: q = floor((2n + den) / (2 den)), sat to Q1.15
    always_comb begin
        qr = {1'b0, r_quo} + 42'd1;
        qr = qr >> 1;
        ofs = '0;
        if (r_state == S_DONE && i_frame.interp && den_ok) begin
            if (r_neg) ofs = (qr > 42'd32768) ? -16'sd32768 : -OFS_W'(qr[15:0]);
            else       ofs = (qr > 42'd32767) ? 16'sd32767 : OFS_W'(qr[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) r_valid <= 1'b1;
            else if (!i_stall) r_valid <= 1'b0;
        end
        if (st_load || (r_state == S_SQRT_C && sqrt_done && i_frame.interp)
            || (r_state == S_SQRT_L && sqrt_done)) begin
            r_root <= '0;
            r_step <= 5'd23;
            r_x    <= st_load ? i_frame.best_sq
                    : (r_state == S_SQRT_C) ? i_frame.left_sq : i_frame.right_sq;
        end else if (r_state == S_SQRT_C || r_state == S_SQRT_L || r_state == S_SQRT_R) begin
            if (sq_try <= r_x) r_root <= root_nx;
            if (!sqrt_done) r_step <= r_step - 1'b1;
        end
        if (r_state == S_SQRT_C && sqrt_done) r_c <= (sq_try <= r_x) ? root_nx : r_root;
        if (r_state == S_SQRT_L && sqrt_done) r_l <= (sq_try <= r_x) ? root_nx : r_root;
        if (r_state == S_SQRT_R && sqrt_done) begin
            r_r <= (sq_try <= r_x) ? root_nx : r_root;
        end
        // divider start: dividend n<<15 (2n<<14), divisor den, 41 quotient bits
        if (r_state == S_SQRT_R && sqrt_done) r_dstep <= 6'd42;
        if (r_state == S_DIV && r_dstep == 6'd42) begin
            r_quo   <= {2'b0, diff, 15'd0};
            r_rem   <= '0;
            r_den   <= 27'(c2 - lr);
            r_neg   <= r_r < r_l;
            r_dstep <= 6'd41;
        end else if (r_state == S_DIV && !div_done) begin
            if (rem_sh >= 42'(r_den)) begin
                r_rem <= 41'(rem_sh - 42'(r_den));
                r_quo <= {r_quo[39:0], 1'b1};
            end else begin
                r_rem <= rem_sh[40:0];
                r_quo <= {r_quo[39:0], 1'b0};
            end
            r_dstep <= r_dstep - 1'b1;
        end
        if (o_pop) begin
            r_item.peak_bin       <= i_frame.best_idx;
            r_item.peak_offset    <= ofs;
            r_item.peak_magnitude <= r_c;
            r_item.band_energy    <= i_frame.energy;
            r_item.detected       <= r_c > i_threshold;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule
`default_nettype wire
